/* sv/bfs_pkg.sv */
// shared constants, payload types and microcode types for the breadth-first walk
package bfs_pkg;

  localparam int MAX_NODES  = 64;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int NODE_W     = 6;
  localparam int ROW_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int STEP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 2'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
  } bfs_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic              last_node;
  } bfs_out_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SEED,
    OP_DEQ,
    OP_FETCH,
    OP_MASK,
    OP_SCAN,
    OP_EMIT,
    OP_NOP
  } bfs_op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_RUN,
    COND_START_BAD,
    COND_CAND_NZ,
    COND_QUEUE_EMPTY
  } bfs_cond_t;

  typedef logic [STEP_W-1:0] bfs_step_t;

  localparam bfs_step_t STEP_IDLE  = 3'd0;
  localparam bfs_step_t STEP_SEED  = 3'd1;
  localparam bfs_step_t STEP_DEQ   = 3'd2;
  localparam bfs_step_t STEP_FETCH = 3'd3;
  localparam bfs_step_t STEP_MASK  = 3'd4;
  localparam bfs_step_t STEP_SCAN  = 3'd5;
  localparam bfs_step_t STEP_EMIT  = 3'd6;
  localparam bfs_step_t STEP_LOOP  = 3'd7;

  typedef struct packed {
    bfs_op_t   op;
    bfs_cond_t cond;
    bfs_step_t target;
  } bfs_uword_t;

  typedef struct packed {
    logic no_run;
    logic start_bad;
    logic cand_nz;
    logic queue_empty;
  } bfs_flags_t;

endpackage

/* sv/bfs_seq.sv */
// microcode sequencer: step counter, control store and conditional jumps
module bfs_seq import bfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  bfs_flags_t flags,
  output bfs_op_t    op,
  output logic       busy
);

  bfs_step_t  pc_r;
  bfs_step_t  pc_nxt;
  bfs_uword_t uword;
  logic       take;

  always_comb begin
    case (pc_r)
      STEP_IDLE:  uword = '{OP_IDLE,  COND_NO_RUN,      STEP_IDLE};
      STEP_SEED:  uword = '{OP_SEED,  COND_START_BAD,   STEP_IDLE};
      STEP_DEQ:   uword = '{OP_DEQ,   COND_NEVER,       STEP_IDLE};
      STEP_FETCH: uword = '{OP_FETCH, COND_NEVER,       STEP_IDLE};
      STEP_MASK:  uword = '{OP_MASK,  COND_NEVER,       STEP_IDLE};
      STEP_SCAN:  uword = '{OP_SCAN,  COND_CAND_NZ,     STEP_SCAN};
      STEP_EMIT:  uword = '{OP_EMIT,  COND_QUEUE_EMPTY, STEP_IDLE};
      STEP_LOOP:  uword = '{OP_NOP,   COND_ALWAYS,      STEP_DEQ};
      default:    uword = '{OP_NOP,   COND_ALWAYS,      STEP_IDLE};
    endcase
  end

  always_comb begin
    case (uword.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_RUN:      take = flags.no_run;
      COND_START_BAD:   take = flags.start_bad;
      COND_CAND_NZ:     take = flags.cand_nz;
      COND_QUEUE_EMPTY: take = flags.queue_empty;
      default:          take = 1'b1;
    endcase
    pc_nxt = take ? uword.target : pc_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op   = uword.op;
  assign busy = (pc_r != STEP_IDLE);

endmodule

/* sv/bfs_adjacency_matrix_walk.sv */
// top level of the breadth-first walk over adjacency-matrix rows
//
// command channel: a transaction is taken when start is high and busy is low.
// cmd = load writes row_bits into adjacency row row_index in that same cycle;
// busy stays low, so loads can follow back to back at one per cycle.
// cmd = run walks the graph breadth first from start_node over the first
// node_count nodes (0 read as 1) and raises busy until the walk is over.
// each visited node appears on out_item for one cycle with out_strobe high;
// last_node marks the final one. the receiver cannot stall: results must be
// taken in the cycle they appear.
// a run seeds, then per dequeued node dequeues, fetches, masks, repeats a scan
// step while new neighbors remain and emits, with a loop step between nodes.
// the microcode loop sets the rate, one queue read and one adjacency memory
// read per node. a run whose start node is not below node_count returns to
// idle from the seed step with no result. config writes (cfg_valid/cfg_ready,
// cfg_ready always high) must be made while busy is low; the block does not
// enforce this. reset clears control state and sets node_count to 64 and
// start_node to 0; adjacency rows must be loaded before use.
module bfs_adjacency_matrix_walk import bfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bfs_in_t               in_item,
  output logic                  out_strobe,
  output bfs_out_t              out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ROW_W-1:0]     adj_mem [MAX_NODES];
  logic [NODE_W-1:0]    q_mem   [MAX_NODES];

  logic [CNT_W-1:0]     node_count_r;
  logic [NODE_W-1:0]    start_node_r;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [CNT_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     tail_r, tail_nxt;
  logic [ROW_W-1:0]     cand_r, cand_nxt;
  logic [NODE_W-1:0]    cur_r;
  logic [NODE_W-1:0]    q_rd_r;
  logic [ROW_W-1:0]     adj_rd_r;
  logic                 out_strobe_r, out_strobe_nxt;
  bfs_out_t             out_item_r, out_item_nxt;

  bfs_op_t              op;
  bfs_flags_t           flags;
  logic                 in_accept;
  logic [CNT_W-1:0]     eff_n;
  logic                 start_bad;
  logic                 cand_nz;
  logic [NODE_W-1:0]    low_idx;
  logic [ROW_W-1:0]     vis_wide;
  logic [ROW_W-1:0]     mask_v;
  logic                 q_we;
  logic [NODE_W-1:0]    q_wdata;

  bfs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op),
    .busy  (busy)
  );

  assign in_accept = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (node_count_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (node_count_r > CNT_W'(MAX_NODES)) begin
      eff_n = CNT_W'(MAX_NODES);
    end else begin
      eff_n = node_count_r;
    end
  end

  assign start_bad = ({1'b0, start_node_r} >= (NODE_W + 1)'(eff_n));
  assign cand_nz   = (cand_r != '0);
  assign vis_wide  = ROW_W'(visited_r);

  assign flags.no_run      = !(in_accept && in_item.cmd == CMD_RUN);
  assign flags.start_bad   = start_bad;
  assign flags.cand_nz     = cand_nz;
  assign flags.queue_empty = (head_r == tail_r);

  // lowest pending neighbor
  always_comb begin
    low_idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand_r[i]) begin
        low_idx = NODE_W'(i);
      end
    end
  end

  // unvisited in-range neighbors, self-loop dropped
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      mask_v[i] = adj_rd_r[i] && (CNT_W'(i) < eff_n) && (NODE_W'(i) != cur_r) && !vis_wide[i];
    end
  end

  always_comb begin
    visited_nxt    = visited_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cand_nxt       = cand_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    q_we           = 1'b0;
    q_wdata        = low_idx;
    case (op)
      OP_IDLE: begin
        if (in_accept && in_item.cmd == CMD_RUN) begin
          visited_nxt = '0;
          head_nxt    = '0;
          tail_nxt    = '0;
        end
      end
      OP_SEED: begin
        if (!start_bad) begin
          visited_nxt[IDX_W'(start_node_r)] = 1'b1;
          tail_nxt = tail_r + CNT_W'(1);
          q_we     = 1'b1;
          q_wdata  = start_node_r;
        end
      end
      OP_DEQ: begin
        head_nxt = head_r + CNT_W'(1);
      end
      OP_MASK: begin
        cand_nxt = mask_v;
      end
      OP_SCAN: begin
        if (cand_nz) begin
          visited_nxt[IDX_W'(low_idx)] = 1'b1;
          tail_nxt = tail_r + CNT_W'(1);
          q_we     = 1'b1;
          cand_nxt = cand_r & (cand_r - ROW_W'(1));
        end
      end
      OP_EMIT: begin
        out_strobe_nxt          = 1'b1;
        out_item_nxt.node_index = cur_r;
        out_item_nxt.last_node  = (head_r == tail_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_item.cmd == CMD_LOAD &&
        {1'b0, in_item.row_index} < (NODE_W + 1)'(MAX_NODES)) begin
      adj_mem[IDX_W'(in_item.row_index)] <= in_item.row_bits;
    end
    if (op == OP_FETCH) begin
      adj_rd_r <= adj_mem[IDX_W'(q_rd_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail_r[IDX_W-1:0]] <= q_wdata;
    end
    if (op == OP_DEQ) begin
      q_rd_r <= q_mem[head_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(MAX_NODES);
      start_node_r <= '0;
      visited_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NODE_COUNT: node_count_r <= CNT_W'(cfg_data);
          CFG_START_NODE: start_node_r <= cfg_data[NODE_W-1:0];
          default: begin
          end
        endcase
      end
      visited_r    <= visited_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    out_item_r <= out_item_nxt;
    if (op == OP_FETCH) begin
      cur_r <= q_rd_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
